>>> hdl/kcba_pkg.sv
// Shared constants, codes and controller/datapath interface types of the block allocator.
`timescale 1ns / 1ps
`default_nettype none
package kcba_pkg;

  localparam int BLOCKS        = 128;
  localparam int PAYLOAD_WORDS = 126;
  localparam int SLOTS         = 32;

  localparam int BLK_W    = 7;
  localparam int SLOT_W   = 5;
  localparam int RBYTES_W = 15;
  localparam int WORD_W   = 16;
  localparam int LINK_W   = 16;
  localparam int BYTES_W  = 16;
  localparam int IDX_W    = 7;
  localparam int CNT_W    = 6;
  localparam int CFG_W    = 16;

  // The used map is scanned one aligned group of blocks per cycle.
  localparam int GRP      = 8;
  localparam int GRP_W    = 3;
  localparam int N_GRPS   = BLOCKS / GRP;
  localparam int GRPIX_W  = BLK_W - GRP_W;
  localparam int STEP_W   = $clog2(N_GRPS + 1);

  localparam logic [BYTES_W-1:0] BLOCK_BYTES = BYTES_W'(2 * PAYLOAD_WORDS);
  localparam logic [LINK_W-1:0]  LAST_LINK   = 16'hFFFF;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 6'd63;

  localparam logic CFG_PIN = 1'b0;
  localparam logic CFG_HDR = 1'b1;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_WORD  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_WAIT_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic start_go;
    logic word_go;
    logic clear_go;
    logic scan_step;
    logic emit;
  } kcba_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       slot_ok;
    logic       active;
    logic       blk_end_last;
    logic       blk_end_full;
    logic       scan_done;
    logic       out_busy;
  } kcba_stat_t;

endpackage
`default_nettype wire

>>> hdl/kcba_ctrl.sv
// Controller state machine that sequences decode, block search and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module kcba_ctrl
  import kcba_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  kcba_stat_t      stat,
  output kcba_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (stat.action)
          ACT_START: begin
            if (stat.slot_ok) begin
              cmd.start_go = 1'b1;
              state_nxt    = ST_SCAN;
            end
          end
          ACT_WORD: begin
            if (stat.active) begin
              cmd.word_go = 1'b1;
              if (stat.blk_end_last) begin
                state_nxt = ST_WAIT_OUT;
              end else if (stat.blk_end_full) begin
                state_nxt = ST_SCAN;
              end
            end
          end
          ACT_CLEAR: begin
            cmd.clear_go = 1'b1;
            state_nxt    = ST_WAIT_OUT;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_WAIT_OUT;
        end
      end
      ST_WAIT_OUT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/kcba_dp.sv
// Datapath: used-block map, slot flags, record state, group-wise free-block search and result registers.
`timescale 1ns / 1ps
`default_nettype none
module kcba_dp
  import kcba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  kcba_cmd_t                cmd,
  output kcba_stat_t               stat,
  input  wire logic [1:0]          in_action,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [RBYTES_W-1:0] in_record_bytes,
  input  wire logic [WORD_W-1:0]   in_data_word,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_kind,
  output logic                     out_status,
  output logic [BLK_W-1:0]         out_block_addr,
  output logic [LINK_W-1:0]        out_next_link,
  output logic                     out_record_done,
  output logic [CNT_W-1:0]         out_record_count
);

  // Configuration.
  logic [15:0]       pin_r;
  logic [BLK_W-1:0]  hdr_r;

  // Latched request.
  logic [1:0]          act_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [RBYTES_W-1:0] rbytes_r;
  logic [WORD_W-1:0]   word_r;

  // Allocation and record state.
  logic [BLOCKS-1:0]   used_r,     used_nxt;
  logic [SLOTS-1:0]    slot_nz_r,  slot_nz_nxt;
  logic [CNT_W-1:0]    cnt_r,      cnt_nxt;
  logic                active_r,   active_nxt;
  logic [BLK_W-1:0]    cur_r,      cur_nxt;
  logic [BYTES_W-1:0]  bytes_r,    bytes_nxt;
  logic [IDX_W-1:0]    idx_r,      idx_nxt;
  logic [WORD_W-1:0]   fold_r,     fold_nxt;
  logic [RBYTES_W-1:0] target_r,   target_nxt;

  // Search state.
  logic [GRPIX_W-1:0] grp_r,     grp_nxt;
  logic [STEP_W-1:0]  step_r,    step_nxt;
  logic [GRP_W-1:0]   off_r,     off_nxt;
  logic               excl_en_r, excl_en_nxt;
  logic               link_r,    link_nxt;
  logic [BLK_W-1:0]   base_r,    base_nxt;

  // Staged result.
  logic [1:0]        res_kind_r,   res_kind_nxt;
  logic              res_status_r, res_status_nxt;
  logic [BLK_W-1:0]  res_addr_r,   res_addr_nxt;
  logic [LINK_W-1:0] res_link_r,   res_link_nxt;
  logic              res_done_r,   res_done_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r;
  logic              out_status_r;
  logic [BLK_W-1:0]  out_addr_r;
  logic [LINK_W-1:0] out_link_r;
  logic              out_done_r;
  logic [CNT_W-1:0]  out_cnt_r;

  // Payload word evaluation.
  logic [IDX_W-1:0]   new_idx;
  logic [WORD_W-1:0]  new_fold;
  logic [BYTES_W:0]   last_sum;
  logic [BYTES_W:0]   done_sum;
  logic               blk_last;
  logic               end_last;
  logic               end_full;
  logic [BLK_W-1:0]   link_base;
  logic [BLK_W-1:0]   first_start;

  // Group search.
  logic [GRP-1:0]     free_vec;
  logic               hit;
  logic [GRP_W-1:0]   hit_k;
  logic [BLK_W-1:0]   hit_blk;
  logic               exhausted;

  assign new_idx   = idx_r + IDX_W'(1);
  assign new_fold  = fold_r ^ word_r;
  assign last_sum  = {1'b0, bytes_r} + {1'b0, BLOCK_BYTES};
  assign done_sum  = {1'b0, bytes_r} + (BYTES_W+1)'({new_idx, 1'b0});
  assign blk_last  = last_sum >= (BYTES_W+1)'(target_r);
  assign end_last  = blk_last && (done_sum >= (BYTES_W+1)'(target_r));
  assign end_full  = !blk_last && (new_idx == IDX_W'(PAYLOAD_WORDS));
  assign link_base = BLK_W'(new_fold ^ pin_r);
  assign first_start = hdr_r + BLK_W'(1);

  // The first group visit skips blocks below the start offset and the revisit of that
  // group at the end of the sweep covers only those blocks, so the order wraps exactly.
  always_comb begin
    for (int k = 0; k < GRP; k++) begin
      logic in_range;
      in_range = 1'b1;
      if (step_r == STEP_W'(0)) begin
        in_range = GRP_W'(k) >= off_r;
      end else if (step_r == STEP_W'(N_GRPS)) begin
        in_range = GRP_W'(k) < off_r;
      end
      if (excl_en_r && (hdr_r == {grp_r, GRP_W'(k)})) begin
        in_range = 1'b0;
      end
      free_vec[k] = in_range && !used_r[{grp_r, GRP_W'(k)}];
    end
  end

  always_comb begin
    hit   = 1'b0;
    hit_k = '0;
    for (int k = GRP - 1; k >= 0; k--) begin
      if (free_vec[k]) begin
        hit   = 1'b1;
        hit_k = GRP_W'(k);
      end
    end
  end

  assign hit_blk   = {grp_r, hit_k};
  assign exhausted = !hit && (step_r == STEP_W'(N_GRPS));

  always_comb begin
    stat.action       = act_r;
    stat.slot_ok      = {1'b0, slot_r} < (SLOT_W+1)'(SLOTS);
    stat.active       = active_r;
    stat.blk_end_last = end_last;
    stat.blk_end_full = end_full;
    stat.scan_done    = hit || exhausted;
    stat.out_busy     = out_valid_r && out_stall;
  end

  always_comb begin
    used_nxt    = used_r;
    slot_nz_nxt = slot_nz_r;
    cnt_nxt     = cnt_r;
    active_nxt  = active_r;
    cur_nxt     = cur_r;
    bytes_nxt   = bytes_r;
    idx_nxt     = idx_r;
    fold_nxt    = fold_r;
    target_nxt  = target_r;
    grp_nxt     = grp_r;
    step_nxt    = step_r;
    off_nxt     = off_r;
    excl_en_nxt = excl_en_r;
    link_nxt    = link_r;
    base_nxt    = base_r;
    res_kind_nxt   = res_kind_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_link_nxt   = res_link_r;
    res_done_nxt   = res_done_r;

    if (cmd.start_go) begin
      if (!slot_nz_r[slot_r] && (cnt_r < CNT_MAX)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      slot_nz_nxt[slot_r] = rbytes_r != '0;
      grp_nxt     = first_start[BLK_W-1:GRP_W];
      off_nxt     = first_start[GRP_W-1:0];
      step_nxt    = '0;
      excl_en_nxt = 1'b1;
      link_nxt    = 1'b0;
    end

    if (cmd.word_go) begin
      fold_nxt = new_fold;
      idx_nxt  = new_idx;
      if (end_last) begin
        active_nxt     = 1'b0;
        res_kind_nxt   = KIND_BLOCK;
        res_status_nxt = 1'b0;
        res_addr_nxt   = cur_r;
        res_link_nxt   = LAST_LINK;
        res_done_nxt   = 1'b1;
      end else if (end_full) begin
        grp_nxt     = link_base[BLK_W-1:GRP_W];
        off_nxt     = link_base[GRP_W-1:0];
        step_nxt    = '0;
        excl_en_nxt = 1'b0;
        link_nxt    = 1'b1;
        base_nxt    = link_base;
      end
    end

    if (cmd.scan_step) begin
      if (hit) begin
        used_nxt[hit_blk] = 1'b1;
        res_status_nxt    = 1'b0;
        res_done_nxt      = 1'b0;
        cur_nxt           = hit_blk;
        idx_nxt           = '0;
        fold_nxt          = '0;
        if (link_r) begin
          res_kind_nxt = KIND_BLOCK;
          res_addr_nxt = cur_r;
          res_link_nxt = LINK_W'(hit_blk) + LINK_W'(base_r);
          bytes_nxt    = bytes_r + BLOCK_BYTES;
        end else begin
          res_kind_nxt = KIND_START;
          res_addr_nxt = hit_blk;
          res_link_nxt = '0;
          bytes_nxt    = '0;
          target_nxt   = rbytes_r;
          active_nxt   = 1'b1;
        end
      end else if (exhausted) begin
        // Store full: the record is dropped and its claimed blocks stay used.
        active_nxt     = 1'b0;
        res_status_nxt = 1'b1;
        res_link_nxt   = '0;
        res_done_nxt   = 1'b1;
        if (link_r) begin
          res_kind_nxt = KIND_BLOCK;
          res_addr_nxt = cur_r;
        end else begin
          res_kind_nxt = KIND_START;
          res_addr_nxt = '0;
        end
      end else begin
        grp_nxt  = grp_r + GRPIX_W'(1);
        step_nxt = step_r + STEP_W'(1);
      end
    end

    if (cmd.clear_go) begin
      used_nxt = '0;
      if ({1'b0, hdr_r} < (BLK_W+1)'(BLOCKS)) begin
        used_nxt[hdr_r] = 1'b1;
      end
      slot_nz_nxt    = '0;
      cnt_nxt        = '0;
      active_nxt     = 1'b0;
      cur_nxt        = '0;
      bytes_nxt      = '0;
      idx_nxt        = '0;
      fold_nxt       = '0;
      target_nxt     = '0;
      res_kind_nxt   = KIND_CLEAR;
      res_status_nxt = 1'b0;
      res_addr_nxt   = hdr_r;
      res_link_nxt   = '0;
      res_done_nxt   = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r       <= '0;
      hdr_r       <= '0;
      used_r      <= '0;
      slot_nz_r   <= '0;
      cnt_r       <= '0;
      active_r    <= 1'b0;
      cur_r       <= '0;
      bytes_r     <= '0;
      idx_r       <= '0;
      fold_r      <= '0;
      target_r    <= '0;
      grp_r       <= '0;
      step_r      <= '0;
      off_r       <= '0;
      excl_en_r   <= 1'b0;
      link_r      <= 1'b0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIN: pin_r <= cfg_wdata;
          CFG_HDR: hdr_r <= cfg_wdata[BLK_W-1:0];
          default: pin_r <= pin_r;
        endcase
      end
      used_r      <= used_nxt;
      slot_nz_r   <= slot_nz_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      cur_r       <= cur_nxt;
      bytes_r     <= bytes_nxt;
      idx_r       <= idx_nxt;
      fold_r      <= fold_nxt;
      target_r    <= target_nxt;
      grp_r       <= grp_nxt;
      step_r      <= step_nxt;
      off_r       <= off_nxt;
      excl_en_r   <= excl_en_nxt;
      link_r      <= link_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r    <= in_action;
      slot_r   <= in_slot;
      rbytes_r <= in_record_bytes;
      word_r   <= in_data_word;
    end
    res_kind_r   <= res_kind_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_link_r   <= res_link_nxt;
    res_done_r   <= res_done_nxt;
    if (cmd.emit) begin
      out_kind_r   <= res_kind_r;
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_link_r   <= res_link_r;
      out_done_r   <= res_done_r;
      out_cnt_r    <= cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_status       = out_status_r;
  assign out_block_addr   = out_addr_r;
  assign out_next_link    = out_link_r;
  assign out_record_done  = out_done_r;
  assign out_record_count = out_cnt_r;

endmodule
`default_nettype wire

>>> hdl/keyed_chained_block_allocator_unit.sv
// Top level of the keyed chained block allocator: controller plus datapath.
//
// Usage: requests arrive on the in_ channel (valid/stall) and are taken one at a time.
// A start request claims the first free block after the header block, a payload word
// request folds a word into the current block, and a clear request frees the store.
// At most one result per request leaves on the out_ channel (valid/stall).
// A start request, and a payload word that fills its block, run the free-block search,
// which walks the used map one group of 8 blocks per cycle; no new request is taken
// until the current one has ended or handed its result to the output register.
// The output register holds a result while the receiver stalls; the next request is
// still taken and worked on, and only its own result waits for the register to free.
// The user writes configuration (cfg_we, cfg_index, cfg_wdata) only while no request
// is pending; the block does not enforce it. Synchronous reset (rst_n low) frees all
// blocks, clears slots, count and registers, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module keyed_chained_block_allocator_unit
  import kcba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_action,
  input  wire logic [SLOT_W-1:0]   in_slot,
  input  wire logic [RBYTES_W-1:0] in_record_bytes,
  input  wire logic [WORD_W-1:0]   in_data_word,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_kind,
  output logic                     out_status,
  output logic [BLK_W-1:0]         out_block_addr,
  output logic [LINK_W-1:0]        out_next_link,
  output logic                     out_record_done,
  output logic [CNT_W-1:0]         out_record_count
);

  kcba_cmd_t  cmd;
  kcba_stat_t stat;

  kcba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kcba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_action),
    .in_slot          (in_slot),
    .in_record_bytes  (in_record_bytes),
    .in_data_word     (in_data_word),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_block_addr   (out_block_addr),
    .out_next_link    (out_next_link),
    .out_record_done  (out_record_done),
    .out_record_count (out_record_count)
  );

endmodule
`default_nettype wire
